// ===== design/vce_pkg.sv =====
package vce_pkg;

    localparam int FRAME_MAX = 15;
    localparam int IDX_W = $clog2(FRAME_MAX);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [3:0] CMD_ABS_MOVE   = 4'd0;
    localparam logic [3:0] CMD_REL_MOVE   = 4'd1;
    localparam logic [3:0] CMD_HOME       = 4'd2;
    localparam logic [3:0] CMD_ZOOM_DIR   = 4'd3;
    localparam logic [3:0] CMD_PRESET     = 4'd4;
    localparam logic [3:0] CMD_CONT_MOVE  = 4'd5;
    localparam logic [3:0] CMD_CONT_ZOOM  = 4'd6;
    localparam logic [3:0] CMD_FOCUS      = 4'd7;
    localparam logic [3:0] CMD_POS_INQ    = 4'd8;
    localparam logic [3:0] CMD_ZOOM_INQ   = 4'd9;

    localparam logic [2:0] ACT_STOP  = 3'd0;
    localparam logic [2:0] ACT_UP    = 3'd1;
    localparam logic [2:0] ACT_DOWN  = 3'd2;
    localparam logic [2:0] ACT_LEFT  = 3'd3;
    localparam logic [2:0] ACT_RIGHT = 3'd4;

    localparam logic [2:0] ACT_ZOOM_STOP = 3'd0;
    localparam logic [2:0] ACT_ZOOM_IN   = 3'd1;

    localparam logic [2:0] ACT_FOCUS_MANUAL = 3'd1;
    localparam logic [2:0] ACT_FOCUS_NEAR   = 3'd2;
    localparam logic [2:0] ACT_FOCUS_FAR    = 3'd3;
    localparam logic [2:0] ACT_FOCUS_STOP   = 3'd4;

    localparam logic [2:0] ACT_PRESET_SET   = 3'd1;
    localparam logic [2:0] ACT_PRESET_CLEAR = 3'd2;

    localparam logic [7:0] BYTE_HEAD = 8'h81;
    localparam logic [7:0] BYTE_TERM = 8'hFF;

    localparam logic signed [15:0] PAN_MIN  = -16'sh0990;
    localparam logic signed [15:0] PAN_MAX  = 16'sh0990;
    localparam logic signed [15:0] TILT_MIN = -16'sh01B0;
    localparam logic signed [15:0] TILT_MAX = 16'sh0510;
    localparam logic signed [15:0] ZOOM_MIN = 16'sh0000;
    localparam logic signed [15:0] ZOOM_MAX = 16'sh4000;
    localparam logic [7:0] PRESET_MAX = 8'd254;

    localparam logic [4:0] PAN_SPEED_MAX  = 5'd24;
    localparam logic [4:0] TILT_SPEED_MAX = 5'd20;

    localparam logic REG_PAN_SPEED  = 1'b0;
    localparam logic REG_TILT_SPEED = 1'b1;

    typedef struct packed {
        logic [FRAME_MAX-1:0][7:0] bytes;
        logic [IDX_W-1:0]          last;
        logic                      rej;
    } t_frame;

endpackage

// ===== design/vce_front.sv =====
module vce_front (
    input  logic [3:0]         i_cmd,
    input  logic [2:0]         i_action,
    input  logic signed [15:0] i_pan_target,
    input  logic signed [15:0] i_tilt_target,
    input  logic signed [15:0] i_zoom_target,
    input  logic [7:0]         i_preset_number,
    input  logic [4:0]         i_pan_speed,
    input  logic [4:0]         i_tilt_speed,
    output logic               o_valid,
    output vce_pkg::t_frame    o_frame
);

    logic signed [15:0] pan_c;
    logic signed [15:0] tilt_c;
    logic signed [15:0] zoom_c;
    logic [7:0]         a;
    logic [7:0]         b;

    always_comb begin
        if (i_pan_target < vce_pkg::PAN_MIN) begin
            pan_c = vce_pkg::PAN_MIN;
        end else if (i_pan_target > vce_pkg::PAN_MAX) begin
            pan_c = vce_pkg::PAN_MAX;
        end else begin
            pan_c = i_pan_target;
        end
        if (i_tilt_target < vce_pkg::TILT_MIN) begin
            tilt_c = vce_pkg::TILT_MIN;
        end else if (i_tilt_target > vce_pkg::TILT_MAX) begin
            tilt_c = vce_pkg::TILT_MAX;
        end else begin
            tilt_c = i_tilt_target;
        end
        if (i_zoom_target < vce_pkg::ZOOM_MIN) begin
            zoom_c = vce_pkg::ZOOM_MIN;
        end else if (i_zoom_target > vce_pkg::ZOOM_MAX) begin
            zoom_c = vce_pkg::ZOOM_MAX;
        end else begin
            zoom_c = i_zoom_target;
        end
    end

    always_comb begin
        o_valid       = 1'b1;
        o_frame       = '0;
        o_frame.bytes[0] = vce_pkg::BYTE_HEAD;
        a = 8'h03;
        b = 8'h03;
        unique case (i_cmd) inside
            vce_pkg::CMD_ABS_MOVE, vce_pkg::CMD_REL_MOVE: begin
                o_frame.bytes[1]  = 8'h01;
                o_frame.bytes[2]  = 8'h06;
                o_frame.bytes[3]  = (i_cmd == vce_pkg::CMD_REL_MOVE) ? 8'h03 : 8'h02;
                o_frame.bytes[4]  = {3'b000, i_pan_speed};
                o_frame.bytes[5]  = {3'b000, i_tilt_speed};
                o_frame.bytes[6]  = {4'h0, pan_c[15:12]};
                o_frame.bytes[7]  = {4'h0, pan_c[11:8]};
                o_frame.bytes[8]  = {4'h0, pan_c[7:4]};
                o_frame.bytes[9]  = {4'h0, pan_c[3:0]};
                o_frame.bytes[10] = {4'h0, tilt_c[15:12]};
                o_frame.bytes[11] = {4'h0, tilt_c[11:8]};
                o_frame.bytes[12] = {4'h0, tilt_c[7:4]};
                o_frame.bytes[13] = {4'h0, tilt_c[3:0]};
                o_frame.bytes[14] = vce_pkg::BYTE_TERM;
                o_frame.last      = 4'd14;
            end
            vce_pkg::CMD_HOME: begin
                o_frame.bytes[1] = 8'h01;
                o_frame.bytes[2] = 8'h06;
                o_frame.bytes[3] = 8'h04;
                o_frame.bytes[4] = vce_pkg::BYTE_TERM;
                o_frame.last     = 4'd4;
            end
            vce_pkg::CMD_ZOOM_DIR: begin
                o_frame.bytes[1] = 8'h01;
                o_frame.bytes[2] = 8'h04;
                o_frame.bytes[3] = 8'h47;
                o_frame.bytes[4] = {4'h0, zoom_c[15:12]};
                o_frame.bytes[5] = {4'h0, zoom_c[11:8]};
                o_frame.bytes[6] = {4'h0, zoom_c[7:4]};
                o_frame.bytes[7] = {4'h0, zoom_c[3:0]};
                o_frame.bytes[8] = vce_pkg::BYTE_TERM;
                o_frame.last     = 4'd8;
            end
            vce_pkg::CMD_PRESET: begin
                if (i_preset_number > vce_pkg::PRESET_MAX) begin
                    o_frame.bytes[0] = 8'h00;
                    o_frame.last     = 4'd0;
                    o_frame.rej      = 1'b1;
                end else begin
                    o_frame.bytes[1] = 8'h01;
                    o_frame.bytes[2] = 8'h04;
                    o_frame.bytes[3] = 8'h3F;
                    o_frame.bytes[4] = (i_action == vce_pkg::ACT_PRESET_SET)   ? 8'h01 :
                                       (i_action == vce_pkg::ACT_PRESET_CLEAR) ? 8'h00 : 8'h02;
                    o_frame.bytes[5] = i_preset_number;
                    o_frame.bytes[6] = vce_pkg::BYTE_TERM;
                    o_frame.last     = 4'd6;
                end
            end
            vce_pkg::CMD_CONT_MOVE: begin
                case (i_action)
                    vce_pkg::ACT_UP: begin
                        a = 8'h03;
                        b = 8'h01;
                    end
                    vce_pkg::ACT_DOWN: begin
                        a = 8'h03;
                        b = 8'h02;
                    end
                    vce_pkg::ACT_LEFT: begin
                        a = 8'h01;
                        b = 8'h03;
                    end
                    vce_pkg::ACT_RIGHT: begin
                        a = 8'h02;
                        b = 8'h03;
                    end
                    default: begin
                        a = 8'h03;
                        b = 8'h03;
                    end
                endcase
                o_frame.bytes[1] = 8'h01;
                o_frame.bytes[2] = 8'h06;
                o_frame.bytes[3] = 8'h01;
                o_frame.bytes[4] = {3'b000, i_pan_speed};
                o_frame.bytes[5] = {3'b000, i_tilt_speed};
                o_frame.bytes[6] = a;
                o_frame.bytes[7] = b;
                o_frame.bytes[8] = vce_pkg::BYTE_TERM;
                o_frame.last     = 4'd8;
            end
            vce_pkg::CMD_CONT_ZOOM: begin
                o_frame.bytes[1] = 8'h01;
                o_frame.bytes[2] = 8'h04;
                o_frame.bytes[3] = 8'h07;
                o_frame.bytes[4] = (i_action == vce_pkg::ACT_ZOOM_STOP) ? 8'h00 :
                                   (i_action == vce_pkg::ACT_ZOOM_IN)   ? 8'h02 : 8'h03;
                o_frame.bytes[5] = vce_pkg::BYTE_TERM;
                o_frame.last     = 4'd5;
            end
            vce_pkg::CMD_FOCUS: begin
                case (i_action)
                    vce_pkg::ACT_FOCUS_MANUAL: begin
                        a = 8'h38;
                        b = 8'h03;
                    end
                    vce_pkg::ACT_FOCUS_NEAR: begin
                        a = 8'h08;
                        b = 8'h02;
                    end
                    vce_pkg::ACT_FOCUS_FAR: begin
                        a = 8'h08;
                        b = 8'h03;
                    end
                    vce_pkg::ACT_FOCUS_STOP: begin
                        a = 8'h08;
                        b = 8'h00;
                    end
                    default: begin
                        a = 8'h38;
                        b = 8'h02;
                    end
                endcase
                o_frame.bytes[1] = 8'h01;
                o_frame.bytes[2] = 8'h04;
                o_frame.bytes[3] = a;
                o_frame.bytes[4] = b;
                o_frame.bytes[5] = vce_pkg::BYTE_TERM;
                o_frame.last     = 4'd5;
            end
            vce_pkg::CMD_POS_INQ: begin
                o_frame.bytes[1] = 8'h09;
                o_frame.bytes[2] = 8'h06;
                o_frame.bytes[3] = 8'h12;
                o_frame.bytes[4] = vce_pkg::BYTE_TERM;
                o_frame.last     = 4'd4;
            end
            vce_pkg::CMD_ZOOM_INQ: begin
                o_frame.bytes[1] = 8'h09;
                o_frame.bytes[2] = 8'h04;
                o_frame.bytes[3] = 8'h47;
                o_frame.bytes[4] = vce_pkg::BYTE_TERM;
                o_frame.last     = 4'd4;
            end
            default: begin
                o_valid = 1'b0;
            end
        endcase
    end

endmodule

// ===== design/vce_queue.sv =====
module vce_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  vce_pkg::t_frame i_data,
    output logic            o_full,
    input  logic            i_rd,
    output logic            o_valid,
    output vce_pkg::t_frame o_data
);

    vce_pkg::t_frame                      r_mem [vce_pkg::QUEUE_DEPTH];
    logic [vce_pkg::QPTR_W-1:0]           r_wp;
    logic [vce_pkg::QPTR_W-1:0]           r_rp;
    logic [vce_pkg::QCNT_W-1:0]           r_cnt;
    logic [vce_pkg::QCNT_W-1:0]           n_cnt;

    assign o_full  = (r_cnt == vce_pkg::QCNT_W'(vce_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if ((i_wr && !o_full) && !(i_rd && o_valid)) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!(i_wr && !o_full) && (i_rd && o_valid)) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_wr && !o_full) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_rd && o_valid) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr && !o_full) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== design/vce_back.sv =====
module vce_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  vce_pkg::t_frame i_q_data,
    output logic            o_q_rd,
    output logic            o_valid,
    input  logic            i_pop,
    output logic [7:0]      o_byte,
    output logic            o_end,
    output logic            o_rej
);

    vce_pkg::t_frame             r_desc;
    logic                        r_have;
    logic [vce_pkg::IDX_W-1:0]   r_idx;
    logic                        r_ovalid;
    logic [7:0]                  r_byte;
    logic                        r_end;
    logic                        r_rej;
    logic                        out_free;
    logic                        emit;
    logic                        is_last;

    assign out_free = !r_ovalid || i_pop;
    assign emit     = r_have && out_free;
    assign is_last  = (r_idx == r_desc.last);
    assign o_q_rd   = i_q_valid && (!r_have || (emit && is_last));

    assign o_valid = r_ovalid;
    assign o_byte  = r_byte;
    assign o_end   = r_end;
    assign o_rej   = r_rej;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have   <= 1'b0;
            r_ovalid <= 1'b0;
            r_idx    <= '0;
        end else begin
            if (o_q_rd) begin
                r_have <= 1'b1;
                r_idx  <= '0;
            end else if (emit) begin
                r_have <= !is_last;
                r_idx  <= r_idx + 1'b1;
            end
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_desc <= i_q_data;
        end
        if (emit) begin
            r_byte <= r_desc.bytes[r_idx];
            r_end  <= is_last;
            r_rej  <= r_desc.rej;
        end
    end

endmodule

// ===== design/visca_command_encoder.sv =====
// A taken command passes from the queue to the descriptor and output byte registers.
// Throughput: one frame byte per cycle while the receiver pops; a frame holds 1 to 15
// bytes, sent by the single byte sequencer; frames follow each other without a gap.
// A two-entry command queue lets commands be taken while an earlier frame drains.
// Synchronous active-low reset empties the queue and result stage and sets the
// pan and tilt speeds to 24 and 20.
module visca_command_encoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [3:0]         i_cmd,
    input  logic [2:0]         i_action,
    input  logic signed [15:0] i_pan_target,
    input  logic signed [15:0] i_tilt_target,
    input  logic signed [15:0] i_zoom_target,
    input  logic [7:0]         i_preset_number,
    output logic               empty,
    input  logic               pop,
    output logic [7:0]         o_frame_byte,
    output logic               o_frame_end,
    output logic               o_rejected,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [4:0]      r_pan_speed;
    logic [4:0]      r_tilt_speed;
    logic [4:0]      n_pan_speed;
    logic [4:0]      n_tilt_speed;
    logic            cfg_wr;
    logic            f_valid;
    vce_pkg::t_frame f_frame;
    logic            q_full;
    logic            q_valid;
    logic            q_rd;
    vce_pkg::t_frame q_data;
    logic            b_valid;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        n_pan_speed  = (pwdata[4:0] > vce_pkg::PAN_SPEED_MAX)  ? vce_pkg::PAN_SPEED_MAX
                                                               : pwdata[4:0];
        n_tilt_speed = (pwdata[4:0] > vce_pkg::TILT_SPEED_MAX) ? vce_pkg::TILT_SPEED_MAX
                                                               : pwdata[4:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pan_speed  <= vce_pkg::PAN_SPEED_MAX;
            r_tilt_speed <= vce_pkg::TILT_SPEED_MAX;
        end else if (cfg_wr) begin
            if (paddr[2] == vce_pkg::REG_PAN_SPEED) begin
                r_pan_speed <= n_pan_speed;
            end else begin
                r_tilt_speed <= n_tilt_speed;
            end
        end
    end

    assign prdata = (paddr[2] == vce_pkg::REG_PAN_SPEED) ? {27'd0, r_pan_speed}
                                                         : {27'd0, r_tilt_speed};

    vce_front u_front (
        .i_cmd           (i_cmd),
        .i_action        (i_action),
        .i_pan_target    (i_pan_target),
        .i_tilt_target   (i_tilt_target),
        .i_zoom_target   (i_zoom_target),
        .i_preset_number (i_preset_number),
        .i_pan_speed     (r_pan_speed),
        .i_tilt_speed    (r_tilt_speed),
        .o_valid         (f_valid),
        .o_frame         (f_frame)
    );

    vce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push && f_valid),
        .i_data  (f_frame),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign full = q_full;

    vce_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_rd    (q_rd),
        .o_valid   (b_valid),
        .i_pop     (pop),
        .o_byte    (o_frame_byte),
        .o_end     (o_frame_end),
        .o_rej     (o_rejected)
    );

    assign empty = !b_valid;

    a_rej_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_rejected) |-> (o_frame_end && o_frame_byte == 8'h00))
        else $error("reject transaction malformed");

    a_term_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_frame_end && !o_rejected) |-> (o_frame_byte == vce_pkg::BYTE_TERM))
        else $error("frame end without terminator");

    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pan_speed <= vce_pkg::PAN_SPEED_MAX) && (r_tilt_speed <= vce_pkg::TILT_SPEED_MAX))
        else $error("speed register out of range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("not empty after reset");

endmodule

// ===== tb/visca_command_encoder_test.sv =====
module visca_command_encoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ACT_PRESET_GOTO = 3'd0;
    localparam logic [2:0] ACT_FOCUS_AUTO  = 3'd0;
    localparam logic [2:0] ACT_UNUSED      = 3'd7;
    localparam logic [3:0] CMD_UNKNOWN_LO  = 4'd10;
    localparam logic [3:0] CMD_UNKNOWN_HI  = 4'd15;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 90;
    localparam int SETTLE       = 40;
    localparam int CYCLE_LIMIT  = 500000;

    typedef struct {
        logic [3:0]         cmd;
        logic [2:0]         action;
        logic signed [15:0] pan;
        logic signed [15:0] tilt;
        logic signed [15:0] zoom;
        logic [7:0]         preset;
    } t_command;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       rejected;
    } t_frame_byte;

    class frame_scoreboard;
        t_frame_byte pending[$];
        logic [7:0]  frame_bytes[$];
        logic [4:0]  pan_speed;
        logic [4:0]  tilt_speed;
        int          errors;

        function new();
            pan_speed  = vce_pkg::PAN_SPEED_MAX;
            tilt_speed = vce_pkg::TILT_SPEED_MAX;
            errors     = 0;
        endfunction

        function void set_speed(input logic index, input logic [31:0] data);
            logic [4:0] v;
            v = data[4:0];
            if (index == vce_pkg::REG_PAN_SPEED) begin
                pan_speed = (v > vce_pkg::PAN_SPEED_MAX) ? vce_pkg::PAN_SPEED_MAX : v;
            end else begin
                tilt_speed = (v > vce_pkg::TILT_SPEED_MAX) ? vce_pkg::TILT_SPEED_MAX : v;
            end
        endfunction

        function logic signed [15:0] clamp(input logic signed [15:0] v, lo, hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function void add_nibbles(input logic signed [15:0] v);
            frame_bytes.push_back({4'h0, v[15:12]});
            frame_bytes.push_back({4'h0, v[11:8]});
            frame_bytes.push_back({4'h0, v[7:4]});
            frame_bytes.push_back({4'h0, v[3:0]});
        endfunction

        function void note_command(input t_command c);
            logic [7:0] a;
            logic [7:0] b;
            frame_bytes = {};
            if (c.cmd == vce_pkg::CMD_PRESET && c.preset > vce_pkg::PRESET_MAX) begin
                pending.push_back('{8'h00, 1'b1, 1'b1});
                return;
            end
            if (c.cmd > vce_pkg::CMD_ZOOM_INQ) return;
            frame_bytes.push_back(vce_pkg::BYTE_HEAD);
            case (c.cmd) inside
                vce_pkg::CMD_ABS_MOVE, vce_pkg::CMD_REL_MOVE: begin
                    frame_bytes.push_back(8'h01);
                    frame_bytes.push_back(8'h06);
                    frame_bytes.push_back(c.cmd == vce_pkg::CMD_REL_MOVE ? 8'h03 : 8'h02);
                    frame_bytes.push_back({3'b000, pan_speed});
                    frame_bytes.push_back({3'b000, tilt_speed});
                    add_nibbles(clamp(c.pan, vce_pkg::PAN_MIN, vce_pkg::PAN_MAX));
                    add_nibbles(clamp(c.tilt, vce_pkg::TILT_MIN, vce_pkg::TILT_MAX));
                end
                vce_pkg::CMD_HOME: begin
                    frame_bytes.push_back(8'h01);
                    frame_bytes.push_back(8'h06);
                    frame_bytes.push_back(8'h04);
                end
                vce_pkg::CMD_ZOOM_DIR: begin
                    frame_bytes.push_back(8'h01);
                    frame_bytes.push_back(8'h04);
                    frame_bytes.push_back(8'h47);
                    add_nibbles(clamp(c.zoom, vce_pkg::ZOOM_MIN, vce_pkg::ZOOM_MAX));
                end
                vce_pkg::CMD_PRESET: begin
                    frame_bytes.push_back(8'h01);
                    frame_bytes.push_back(8'h04);
                    frame_bytes.push_back(8'h3F);
                    frame_bytes.push_back(c.action == vce_pkg::ACT_PRESET_SET   ? 8'h01 :
                                          c.action == vce_pkg::ACT_PRESET_CLEAR ? 8'h00 : 8'h02);
                    frame_bytes.push_back(c.preset);
                end
                vce_pkg::CMD_CONT_MOVE: begin
                    case (c.action)
                        vce_pkg::ACT_UP:    begin a = 8'h03; b = 8'h01; end
                        vce_pkg::ACT_DOWN:  begin a = 8'h03; b = 8'h02; end
                        vce_pkg::ACT_LEFT:  begin a = 8'h01; b = 8'h03; end
                        vce_pkg::ACT_RIGHT: begin a = 8'h02; b = 8'h03; end
                        default:            begin a = 8'h03; b = 8'h03; end
                    endcase
                    frame_bytes.push_back(8'h01);
                    frame_bytes.push_back(8'h06);
                    frame_bytes.push_back(8'h01);
                    frame_bytes.push_back({3'b000, pan_speed});
                    frame_bytes.push_back({3'b000, tilt_speed});
                    frame_bytes.push_back(a);
                    frame_bytes.push_back(b);
                end
                vce_pkg::CMD_CONT_ZOOM: begin
                    frame_bytes.push_back(8'h01);
                    frame_bytes.push_back(8'h04);
                    frame_bytes.push_back(8'h07);
                    frame_bytes.push_back(c.action == vce_pkg::ACT_ZOOM_STOP ? 8'h00 :
                                          c.action == vce_pkg::ACT_ZOOM_IN   ? 8'h02 : 8'h03);
                end
                vce_pkg::CMD_FOCUS: begin
                    case (c.action)
                        vce_pkg::ACT_FOCUS_MANUAL: begin a = 8'h38; b = 8'h03; end
                        vce_pkg::ACT_FOCUS_NEAR:   begin a = 8'h08; b = 8'h02; end
                        vce_pkg::ACT_FOCUS_FAR:    begin a = 8'h08; b = 8'h03; end
                        vce_pkg::ACT_FOCUS_STOP:   begin a = 8'h08; b = 8'h00; end
                        default:                   begin a = 8'h38; b = 8'h02; end
                    endcase
                    frame_bytes.push_back(8'h01);
                    frame_bytes.push_back(8'h04);
                    frame_bytes.push_back(a);
                    frame_bytes.push_back(b);
                end
                vce_pkg::CMD_POS_INQ: begin
                    frame_bytes.push_back(8'h09);
                    frame_bytes.push_back(8'h06);
                    frame_bytes.push_back(8'h12);
                end
                default: begin
                    frame_bytes.push_back(8'h09);
                    frame_bytes.push_back(8'h04);
                    frame_bytes.push_back(8'h47);
                end
            endcase
            frame_bytes.push_back(vce_pkg::BYTE_TERM);
            foreach (frame_bytes[i]) begin
                pending.push_back('{frame_bytes[i], 1'(i == frame_bytes.size() - 1), 1'b0});
            end
        endfunction

        function void check_byte(input logic [7:0] fb, input logic fe, input logic rj);
            t_frame_byte want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected byte, expected none, got %02h end %0b rej %0b",
                         $time, fb, fe, rj);
                return;
            end
            want = pending.pop_front();
            if (fb !== want.value) begin
                errors++;
                $display("%0t: frame_byte expected %02h, got %02h", $time, want.value, fb);
            end
            if (fe !== want.last) begin
                errors++;
                $display("%0t: frame_end expected %0b, got %0b", $time, want.last, fe);
            end
            if (rj !== want.rejected) begin
                errors++;
                $display("%0t: rejected expected %0b, got %0b", $time, want.rejected, rj);
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic [3:0]         i_cmd;
    logic [2:0]         i_action;
    logic signed [15:0] i_pan_target;
    logic signed [15:0] i_tilt_target;
    logic signed [15:0] i_zoom_target;
    logic [7:0]         i_preset_number;
    logic               empty;
    logic               pop;
    logic [7:0]         o_frame_byte;
    logic               o_frame_end;
    logic               o_rejected;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    frame_scoreboard sb;
    bit              calm = 1'b0;
    int              send_odds = 0;
    int              pop_odds = 0;
    int              cycles = 0;

    visca_command_encoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_cmd           (i_cmd),
        .i_action        (i_action),
        .i_pan_target    (i_pan_target),
        .i_tilt_target   (i_tilt_target),
        .i_zoom_target   (i_zoom_target),
        .i_preset_number (i_preset_number),
        .empty           (empty),
        .pop             (pop),
        .o_frame_byte    (o_frame_byte),
        .o_frame_end     (o_frame_end),
        .o_rejected      (o_rejected),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_command seen;
        if (i_rst_n) begin
            if (push && !full) begin
                seen = '{i_cmd, i_action, i_pan_target, i_tilt_target, i_zoom_target,
                         i_preset_number};
                sb.note_command(seen);
            end
            if (pop && !empty) begin
                sb.check_byte(o_frame_byte, o_frame_end, o_rejected);
            end
        end
    end

    // Receiver: random stall bursts, with the stall odds reshuffled during the run
    initial begin : receiver
        int n;
        pop <= 1'b0;
        n = 0;
        forever begin
            @(negedge i_clk);
            n++;
            if (n % 64 == 0) pop_odds = $urandom_range(0, 3) * 8;
            if (!calm && i_rst_n && $urandom_range(0, 99) < pop_odds) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 12) - 1) @(negedge i_clk);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    function automatic t_command make_command(logic [3:0] cmd, logic [2:0] act,
                                              int pan = 0, int tilt = 0, int zoom = 0,
                                              int preset = 0);
        t_command c;
        c.cmd    = cmd;
        c.action = act;
        c.pan    = 16'(pan);
        c.tilt   = 16'(tilt);
        c.zoom   = 16'(zoom);
        c.preset = 8'(preset);
        return c;
    endfunction

    function automatic t_command random_command();
        t_command c;
        int       r;
        r = $urandom_range(0, 19);
        c.cmd    = (r < 18) ? 4'(r % 10) : 4'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
        c.action = 3'($urandom_range(0, 7));
        c.pan    = $urandom_range(0, 1) ? 16'($urandom)
                                        : 16'($urandom_range(0, 16'h1320) - 16'h0990);
        c.tilt   = $urandom_range(0, 1) ? 16'($urandom)
                                        : 16'($urandom_range(0, 16'h06C0) - 16'h01B0);
        c.zoom   = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 16'h4000));
        c.preset = ($urandom_range(0, 9) == 0) ? 8'hFF
                                               : 8'($urandom_range(0, vce_pkg::PRESET_MAX));
        return c;
    endfunction

    task automatic send_command(input t_command c);
        @(negedge i_clk);
        push            <= 1'b1;
        i_cmd           <= c.cmd;
        i_action        <= c.action;
        i_pan_target    <= c.pan;
        i_tilt_target   <= c.tilt;
        i_zoom_target   <= c.zoom;
        i_preset_number <= c.preset;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic pause_sender(input int n);
        @(negedge i_clk);
        push <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Hold input until every expected byte has drained, then settle
    task automatic drain(input int settle);
        @(negedge i_clk);
        push <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_register(input logic index, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_speed(index, data);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_directed();
        send_command(make_command(vce_pkg::CMD_ABS_MOVE, vce_pkg::ACT_STOP, 32767, -32768));
        send_command(make_command(vce_pkg::CMD_REL_MOVE, ACT_UNUSED, -32768, 32767));
        send_command(make_command(vce_pkg::CMD_ABS_MOVE, vce_pkg::ACT_STOP,
                                  16'h0990, -16'h01B0));
        send_command(make_command(vce_pkg::CMD_REL_MOVE, vce_pkg::ACT_STOP, -1, 16'h0510));
        send_command(make_command(vce_pkg::CMD_HOME, ACT_UNUSED));
        send_command(make_command(vce_pkg::CMD_ZOOM_DIR, vce_pkg::ACT_STOP, 0, 0, -1));
        send_command(make_command(vce_pkg::CMD_ZOOM_DIR, vce_pkg::ACT_STOP, 0, 0, 16'h4000));
        send_command(make_command(vce_pkg::CMD_ZOOM_DIR, vce_pkg::ACT_STOP, 0, 0, 32767));
        send_command(make_command(vce_pkg::CMD_PRESET, ACT_PRESET_GOTO, 0, 0, 0, 0));
        send_command(make_command(vce_pkg::CMD_PRESET, vce_pkg::ACT_PRESET_SET,
                                  0, 0, 0, vce_pkg::PRESET_MAX));
        send_command(make_command(vce_pkg::CMD_PRESET, vce_pkg::ACT_PRESET_CLEAR,
                                  0, 0, 0, 8'h5A));
        send_command(make_command(vce_pkg::CMD_PRESET, ACT_UNUSED, 0, 0, 0, 8'hA5));
        send_command(make_command(vce_pkg::CMD_PRESET, vce_pkg::ACT_PRESET_SET,
                                  0, 0, 0, 8'hFF));
        send_command(make_command(vce_pkg::CMD_CONT_MOVE, vce_pkg::ACT_STOP));
        send_command(make_command(vce_pkg::CMD_CONT_MOVE, vce_pkg::ACT_UP));
        send_command(make_command(vce_pkg::CMD_CONT_MOVE, vce_pkg::ACT_DOWN));
        send_command(make_command(vce_pkg::CMD_CONT_MOVE, vce_pkg::ACT_LEFT));
        send_command(make_command(vce_pkg::CMD_CONT_MOVE, vce_pkg::ACT_RIGHT));
        send_command(make_command(vce_pkg::CMD_CONT_MOVE, ACT_UNUSED));
        send_command(make_command(vce_pkg::CMD_CONT_ZOOM, vce_pkg::ACT_ZOOM_STOP));
        send_command(make_command(vce_pkg::CMD_CONT_ZOOM, vce_pkg::ACT_ZOOM_IN));
        send_command(make_command(vce_pkg::CMD_CONT_ZOOM, ACT_UNUSED));
        send_command(make_command(vce_pkg::CMD_FOCUS, ACT_FOCUS_AUTO));
        send_command(make_command(vce_pkg::CMD_FOCUS, vce_pkg::ACT_FOCUS_MANUAL));
        send_command(make_command(vce_pkg::CMD_FOCUS, vce_pkg::ACT_FOCUS_NEAR));
        send_command(make_command(vce_pkg::CMD_FOCUS, vce_pkg::ACT_FOCUS_FAR));
        send_command(make_command(vce_pkg::CMD_FOCUS, vce_pkg::ACT_FOCUS_STOP));
        send_command(make_command(vce_pkg::CMD_FOCUS, ACT_UNUSED));
        send_command(make_command(vce_pkg::CMD_POS_INQ, ACT_UNUSED));
        send_command(make_command(vce_pkg::CMD_ZOOM_INQ, vce_pkg::ACT_STOP));
        send_command(make_command(CMD_UNKNOWN_LO, vce_pkg::ACT_STOP));
        send_command(make_command(CMD_UNKNOWN_HI, ACT_UNUSED, -1, -1, -1, 8'hFF));
    endtask

    initial begin : stimulus
        logic [31:0] pan_setting[PHASES];
        logic [31:0] tilt_setting[PHASES];
        sb = new();
        pan_setting  = '{32'd0, 32'd31, 32'd25, 32'd0, 32'(vce_pkg::PAN_SPEED_MAX)};
        tilt_setting = '{32'd0, 32'd31, 32'd21, 32'd0, 32'(vce_pkg::TILT_SPEED_MAX)};
        i_rst_n         = 1'b0;
        push            = 1'b0;
        i_cmd           = vce_pkg::CMD_HOME;
        i_action        = vce_pkg::ACT_STOP;
        i_pan_target    = '0;
        i_tilt_target   = '0;
        i_zoom_target   = '0;
        i_preset_number = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        drain(SETTLE);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase == 3) begin
                pan_setting[phase]  = $urandom;
                tilt_setting[phase] = $urandom;
            end
            write_register(vce_pkg::REG_PAN_SPEED, pan_setting[phase]);
            write_register(vce_pkg::REG_TILT_SPEED, tilt_setting[phase]);
            calm = (phase == PHASES - 1);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k % 30 == 0) send_odds = calm ? 0 : $urandom_range(0, 3) * 10;
                if ($urandom_range(0, 99) < send_odds) pause_sender($urandom_range(1, 12));
                send_command(random_command());
                if (phase == 2 && k == PHASE_ITEMS / 2) drain(0);
            end
            drain(SETTLE);
        end

        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/vce_pkg.sv
design/vce_front.sv
design/vce_queue.sv
design/vce_back.sv
design/visca_command_encoder.sv
tb/visca_command_encoder_test.sv
